[sv/fpa_pkg.sv]
package fpa_pkg;

	typedef enum logic [3:0] {
		OP_ADD   = 4'd0,
		OP_SUB   = 4'd1,
		OP_MUL   = 4'd2,
		OP_DIV   = 4'd3,
		OP_GT    = 4'd4,
		OP_LT    = 4'd5,
		OP_GE    = 4'd6,
		OP_LE    = 4'd7,
		OP_EQ    = 4'd8,
		OP_NE    = 4'd9,
		OP_MIN   = 4'd10,
		OP_MAX   = 4'd11,
		OP_INC   = 4'd12,
		OP_DEC   = 4'd13,
		OP_TOINT = 4'd14
	} func_t;

	// flags that follow an item down the divider row
	typedef struct packed {
		logic valid;
		logic neg;
		logic is_div;
		logic dbz;
	} dctl_t;

endpackage

[sv/fpa_div_cell.sv]
// One restoring-division step per cell; each cell adds a pipeline stage.
module fpa_div_cell
	import fpa_pkg::*;
#(
	parameter int NW = 40,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  dctl_t         ctl_in,
	input  logic [NW-1:0] num_in,
	input  logic [DW:0]   rem_in,
	input  logic [DW-1:0] den_in,
	output dctl_t         ctl_out,
	output logic [NW-1:0] num_out,
	output logic [DW:0]   rem_out,
	output logic [DW-1:0] den_out
);
	logic [DW+1:0] shifted;
	logic [DW+1:0] diff;
	logic          take;

	always_comb begin
		shifted = {rem_in, num_in[NW-1]};
		diff    = shifted - {2'b00, den_in};
		take    = !diff[DW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	// num doubles as quotient: bits shift out the top, quotient bits shift in
	always_ff @(posedge clk) begin
		num_out <= {num_in[NW-2:0], take};
		rem_out <= take ? diff[DW:0] : shifted[DW:0];
		den_out <= den_in;
	end
endmodule

[sv/fpa_mul.sv]
// Magnitude multiply with round-half-up; latency matches the divider row.
module fpa_mul
	import fpa_pkg::*;
#(
	parameter int DW = 32,
	parameter int FB = 8,
	parameter int LAT = 41
) (
	input  logic            clk,
	input  logic [DW-1:0]   ma,
	input  logic [DW-1:0]   mb,
	output logic [2*DW-1:0] prod
);
	localparam int HW = (DW + 1) / 2;
	localparam int PW = 2 * DW;

	logic [DW-1:0] ma_s1, mb_s1;
	logic [PW-1:0] p00_s2, p01_s2, p10_s2, p11_s2;
	logic [PW:0]   sum_s3;
	logic [PW:0]   pipe_q [LAT-3];
	logic [DW-1:0] a_hi, a_lo, b_hi, b_lo;

	always_comb begin
		a_lo = ma_s1 & ((DW'(1) << HW) - DW'(1));
		b_lo = mb_s1 & ((DW'(1) << HW) - DW'(1));
		a_hi = ma_s1 >> HW;
		b_hi = mb_s1 >> HW;
	end

	always_ff @(posedge clk) begin
		ma_s1  <= ma;
		mb_s1  <= mb;
		p00_s2 <= PW'(a_lo) * PW'(b_lo);
		p01_s2 <= (PW'(a_lo) * PW'(b_hi)) << HW;
		p10_s2 <= (PW'(a_hi) * PW'(b_lo)) << HW;
		p11_s2 <= (PW'(a_hi) * PW'(b_hi)) << (2 * HW);
		sum_s3 <= ({1'b0, p00_s2} + {1'b0, p01_s2}) + ({1'b0, p10_s2} + {1'b0, p11_s2})
			+ ((FB > 0) ? ((PW + 1)'(1) << ((FB > 0) ? FB - 1 : 0)) : '0);
	end

	genvar g;
	for (g = 0; g < LAT - 3; g++) begin : g_dly
		if (g == 0) begin : g_first
			always_ff @(posedge clk) pipe_q[g] <= sum_s3;
		end else begin : g_rest
			always_ff @(posedge clk) pipe_q[g] <= pipe_q[g-1];
		end
	end

	// product of two DW-bit magnitudes fits in PW bits plus rounding; saturate top bit
	assign prod = pipe_q[LAT-4][PW] ? {PW{1'b1}} : PW'(pipe_q[LAT-4] >> FB);
endmodule

[sv/fixed_point_alu_top.sv]
// An accepted op passes the divider row cells, then the output register, before its done strobe.
// Throughput: one beat per cycle; busy is tied low, every op uses the same latency.
// Divide runs through a row of one-bit restoring cells; multiply is a 4-part product.
// Reset (arst_n low) clears the divider-row control flags and done only; no result is dropped afterward.
// The receiver cannot stall: each result shows for one cycle with done high.
module fixed_point_alu_top
	import fpa_pkg::*;
#(
	parameter int FRAC_BITS = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [3:0]                   func,
	input  logic signed [DATA_WIDTH-1:0] operand_a,
	input  logic signed [DATA_WIDTH-1:0] operand_b,
	output logic                         done,
	output logic signed [DATA_WIDTH-1:0] result_value,
	output logic                         compare_true,
	output logic                         overflow,
	output logic                         divide_by_zero
);
	localparam int DW  = DATA_WIDTH;
	localparam int NW  = DW + FRAC_BITS;
	localparam int LAT = NW + 1;
	localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

	assign busy = 1'b0;

	logic [DW-1:0] ma, mb, ka, kb, add_r, sub_r, inc_r, dec_r, fast_r;
	logic          neg, a_s, b_s, fast_cmp, fast_ovf, is_mul;
	logic          ov_add, ov_sub, ov_inc, ov_dec;
	func_t         op;

	always_comb begin
		op    = func_t'(func);
		a_s   = operand_a[DW-1];
		b_s   = operand_b[DW-1];
		ma    = a_s ? DW'(-operand_a) : operand_a;
		mb    = b_s ? DW'(-operand_b) : operand_b;
		neg   = a_s ^ b_s;
		ka    = operand_a ^ VMIN;
		kb    = operand_b ^ VMIN;
		add_r = operand_a + operand_b;
		sub_r = operand_a - operand_b;
		inc_r = operand_a + DW'(1);
		dec_r = operand_a - DW'(1);
		ov_add = (a_s == b_s) && (add_r[DW-1] != a_s);
		ov_sub = (a_s != b_s) && (sub_r[DW-1] != a_s);
		ov_inc = !a_s && inc_r[DW-1];
		ov_dec = a_s && !dec_r[DW-1];
		fast_r = '0;
		fast_cmp = 1'b0;
		fast_ovf = 1'b0;
		is_mul = 1'b0;
		unique case (op)
			OP_ADD: begin
				fast_r = ov_add ? (a_s ? VMIN : VMAX) : add_r;
				fast_ovf = ov_add;
			end
			OP_SUB: begin
				fast_r = ov_sub ? (a_s ? VMIN : VMAX) : sub_r;
				fast_ovf = ov_sub;
			end
			OP_MUL: is_mul = 1'b1;
			OP_DIV: ;
			OP_GT: fast_cmp = ka > kb;
			OP_LT: fast_cmp = ka < kb;
			OP_GE: fast_cmp = ka >= kb;
			OP_LE: fast_cmp = ka <= kb;
			OP_EQ: fast_cmp = ka == kb;
			OP_NE: fast_cmp = ka != kb;
			OP_MIN: fast_r = (ka < kb) ? operand_a : operand_b;
			OP_MAX: fast_r = (ka > kb) ? operand_a : operand_b;
			OP_INC: begin
				fast_r = ov_inc ? VMAX : inc_r;
				fast_ovf = ov_inc;
			end
			OP_DEC: begin
				fast_r = ov_dec ? VMIN : dec_r;
				fast_ovf = ov_dec;
			end
			OP_TOINT: fast_r = DW'(operand_a >>> FRAC_BITS);
			default: ;
		endcase
	end

	// side delay line for the non-divide results, and the multiplier
	logic [DW+3:0] side_q [LAT-1];
	logic [2*DW-1:0] prod;

	genvar g;
	for (g = 0; g < LAT - 1; g++) begin : g_side
		if (g == 0) begin : g_first
			always_ff @(posedge clk)
				side_q[g] <= {fast_r, fast_cmp, fast_ovf, is_mul, neg};
		end else begin : g_rest
			always_ff @(posedge clk) side_q[g] <= side_q[g-1];
		end
	end

	fpa_mul #(.DW(DW), .FB(FRAC_BITS), .LAT(NW)) u_mul (
		.clk (clk),
		.ma  (ma),
		.mb  (mb),
		.prod(prod)
	);

	// divider row: one cell per numerator bit
	dctl_t         ctl_c [NW+1];
	logic [NW-1:0] num_c [NW+1];
	logic [DW:0]   rem_c [NW+1];
	logic [DW-1:0] den_c [NW+1];

	always_comb begin
		ctl_c[0].valid  = start;
		ctl_c[0].neg    = neg;
		ctl_c[0].is_div = (op == OP_DIV);
		ctl_c[0].dbz    = (op == OP_DIV) && (operand_b == '0);
		num_c[0] = NW'(ma) << FRAC_BITS;
		rem_c[0] = '0;
		den_c[0] = mb;
	end

	for (g = 0; g < NW; g++) begin : g_cell
		fpa_div_cell #(.NW(NW), .DW(DW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_in (ctl_c[g]),
			.num_in (num_c[g]),
			.rem_in (rem_c[g]),
			.den_in (den_c[g]),
			.ctl_out(ctl_c[g+1]),
			.num_out(num_c[g+1]),
			.rem_out(rem_c[g+1]),
			.den_out(den_c[g+1])
		);
	end

	// sign of dividend for divide-by-zero, carried alongside
	logic ctl_sign_q;
	logic [LAT-2:0] asign_q;
	always_ff @(posedge clk) asign_q <= {asign_q[LAT-3:0], a_s};
	assign ctl_sign_q = asign_q[LAT-2];

	// final stage: rounding of quotient, saturation, output register
	logic [DW+1:0] twice_rem;
	logic [NW:0]   qr;
	logic          rnd, o_neg, o_mul;
	logic [NW:0]   mag;
	logic [DW-1:0] o_val;
	logic          o_ovf;

	always_comb begin
		twice_rem = {rem_c[NW], 1'b0};
		rnd   = twice_rem >= {2'b00, den_c[NW]};
		qr    = {1'b0, num_c[NW]} + (NW+1)'(rnd);
		o_neg = side_q[LAT-2][0];
		o_mul = side_q[LAT-2][1];
		mag   = o_mul ? ((|prod[2*DW-1:NW]) ? {(NW+1){1'b1}} : (NW+1)'(prod)) : qr;
		o_val = side_q[LAT-2][DW+3:4];
		o_ovf = side_q[LAT-2][2];
		if (ctl_c[NW].dbz) begin
			o_val = ctl_sign_q ? VMIN : VMAX;
		end else if (ctl_c[NW].is_div || o_mul) begin
			if (!o_neg) begin
				o_ovf = mag > (NW+1)'(VMAX);
				o_val = o_ovf ? VMAX : DW'(mag);
			end else begin
				o_ovf = mag > (NW+1)'(VMAX) + (NW+1)'(1);
				o_val = o_ovf ? VMIN : DW'(-mag);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_c[NW].valid;
		end
	end

	always_ff @(posedge clk) begin
		result_value   <= o_val;
		compare_true   <= side_q[LAT-2][3];
		overflow       <= o_ovf && !ctl_c[NW].dbz;
		divide_by_zero <= ctl_c[NW].dbz;
	end

	a_flag_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(overflow && divide_by_zero))
		else $error("overflow and divide_by_zero together");
	a_cmp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && compare_true |-> result_value == '0)
		else $error("comparison with nonzero value");
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c[NW].valid |=> done)
		else $error("divider row valid lost");
endmodule

[tb/fixed_point_alu_top_tb.sv]
`timescale 1ns / 1ps
module fixed_point_alu_top_tb;
	import fpa_pkg::*;

	localparam int FRAC = 8;
	localparam int W = 32;
	localparam int LATENCY = W + FRAC + 2;
	localparam longint MAX_CYCLES = 400000;
	localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] NEG_MAX = {1'b1, {(W-1){1'b0}}};

	typedef struct {
		logic [3:0]   func;
		logic [W-1:0] a;
		logic [W-1:0] b;
	} alu_op_t;

	typedef struct {
		logic [W-1:0] value;
		logic         cmp;
		logic         ovf;
		logic         dbz;
	} alu_res_t;

	logic clk, arst_n, start, busy, done;
	logic [3:0] func;
	logic signed [W-1:0] operand_a, operand_b;
	logic signed [W-1:0] result_value;
	logic compare_true, overflow, divide_by_zero;

	alu_op_t  pending_ops[$];
	alu_res_t expected_res[$];
	int  errors = 0;
	int  send_idle_pct = 0;
	longint cycle_count = 0;

	fixed_point_alu_top #(.FRAC_BITS(FRAC), .DATA_WIDTH(W)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .operand_a(operand_a), .operand_b(operand_b),
		.done(done), .result_value(result_value), .compare_true(compare_true),
		.overflow(overflow), .divide_by_zero(divide_by_zero)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// signed magnitude to raw with saturation
	function automatic logic [W-1:0] sat_pack(input bit neg, input logic [127:0] mag,
		inout logic ovf);
		if (!neg) begin
			if (mag > {96'd0, POS_MAX}) begin
				ovf = 1;
				return POS_MAX;
			end
			return mag[W-1:0];
		end
		if (mag > {96'd0, NEG_MAX}) begin
			ovf = 1;
			return NEG_MAX;
		end
		return -mag[W-1:0];
	endfunction

	function automatic alu_res_t alu_predict(input alu_op_t op);
		alu_res_t r;
		logic signed [W-1:0] sa, sb;
		logic signed [W:0] sum;
		logic [127:0] ma, mb, prod, num, quo, rem;
		bit neg;
		sa = op.a;
		sb = op.b;
		r = '{default: 0};
		ma = sa[W-1] ? 128'(-{1'b1, sa}) : 128'(sa);
		mb = sb[W-1] ? 128'(-{1'b1, sb}) : 128'(sb);
		ma = ma & {96'd0, {W{1'b1}}} | (sa == NEG_MAX ? 128'(NEG_MAX) : 0);
		mb = mb & {96'd0, {W{1'b1}}} | (sb == NEG_MAX ? 128'(NEG_MAX) : 0);
		neg = sa[W-1] ^ sb[W-1];
		case (op.func)
			OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
				case (op.func)
					OP_ADD: sum = sa + sb;
					OP_SUB: sum = sa - sb;
					OP_INC: sum = sa + 1;
					default: sum = sa - 1;
				endcase
				if (sum > $signed({2'b0, POS_MAX[W-2:0]})) begin
					r.ovf = 1;
					r.value = POS_MAX;
				end else if (sum < -$signed({2'b0, POS_MAX[W-2:0]}) - 1) begin
					r.ovf = 1;
					r.value = NEG_MAX;
				end else
					r.value = sum[W-1:0];
			end
			OP_MUL: begin
				prod = (ma * mb + (128'd1 << (FRAC - 1))) >> FRAC;
				r.value = sat_pack(neg, prod, r.ovf);
			end
			OP_DIV: begin
				if (sb == 0) begin
					r.dbz = 1;
					r.value = sa[W-1] ? NEG_MAX : POS_MAX;
				end else begin
					num = ma << FRAC;
					quo = num / mb;
					rem = num % mb;
					if (rem >= mb - rem)
						quo = quo + 1;
					r.value = sat_pack(neg, quo, r.ovf);
				end
			end
			OP_GT: r.cmp = sa > sb;
			OP_LT: r.cmp = sa < sb;
			OP_GE: r.cmp = sa >= sb;
			OP_LE: r.cmp = sa <= sb;
			OP_EQ: r.cmp = sa == sb;
			OP_NE: r.cmp = sa != sb;
			OP_MIN: r.value = sa < sb ? sa : sb;
			OP_MAX: r.value = sa > sb ? sa : sb;
			OP_TOINT: r.value = sa >>> FRAC;
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [W-1:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return POS_MAX - $urandom_range(0, 2);
			1: return NEG_MAX + $urandom_range(0, 2);
			2: return $urandom_range(0, 3) - 1;
			3, 4: return W'($signed($urandom_range(0, 1 << 16)) - (1 << 15));
			5: return W'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
			default: return $urandom();
		endcase
	endfunction

	task automatic queue_op(input func_t f, input logic [W-1:0] a, input logic [W-1:0] b);
		alu_op_t op;
		op.func = f;
		op.a = a;
		op.b = b;
		pending_ops.push_back(op);
	endtask

	// driver: one beat when start is high at a rising edge with busy low
	always @(negedge clk) begin
		if (arst_n && start && !busy)
			expected_res.push_back(alu_predict('{func, operand_a, operand_b}));
		if (arst_n && !(start && busy) && pending_ops.size() > 0 &&
			$urandom_range(1, 100) > send_idle_pct) begin
			alu_op_t op;
			op = pending_ops.pop_front();
			start <= 1;
			func <= op.func;
			operand_a <= op.a;
			operand_b <= op.b;
		end else if (!(start && busy))
			start <= 0;
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_res.size() == 0) begin
				$display("%0t: unexpected result value=%h", $time, result_value);
				errors++;
			end else begin
				alu_res_t e;
				e = expected_res.pop_front();
				if (result_value !== e.value || compare_true !== e.cmp ||
					overflow !== e.ovf || divide_by_zero !== e.dbz) begin
					$display("%0t: mismatch expected value=%h cmp=%b ovf=%b dbz=%b",
						$time, e.value, e.cmp, e.ovf, e.dbz);
					$display("%0t:          actual   value=%h cmp=%b ovf=%b dbz=%b",
						$time, result_value, compare_true, overflow, divide_by_zero);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > MAX_CYCLES) begin
			$display("fixed_point_alu_top_tb: errors");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		start = 0;
		func = 0;
		operand_a = 0;
		operand_b = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: extremes, every op, saturation, divide by zero, rounding halves
		for (int f = OP_ADD; f <= OP_TOINT; f++)
			queue_op(func_t'(f), 32'h0000_0300, 32'hFFFF_FE80);
		queue_op(OP_ADD, POS_MAX, 1);
		queue_op(OP_SUB, NEG_MAX, 1);
		queue_op(OP_MUL, POS_MAX, POS_MAX);
		queue_op(OP_MUL, NEG_MAX, 32'h0000_0100);
		queue_op(OP_MUL, 32'h0000_0080, 32'hFFFF_FF01);
		queue_op(OP_DIV, 32'h0000_0500, 0);
		queue_op(OP_DIV, NEG_MAX, 0);
		queue_op(OP_DIV, NEG_MAX, 32'hFFFF_FF00);
		queue_op(OP_DIV, 32'h0000_0001, 32'h0000_0200);
		queue_op(OP_INC, POS_MAX, 0);
		queue_op(OP_DEC, NEG_MAX, 0);
		queue_op(OP_TOINT, 32'hFFFF_FFFF, POS_MAX);
		queue_op(func_t'(4'd15), POS_MAX, NEG_MAX);

		for (int phase = 0; phase < 4; phase++) begin
			wait (pending_ops.size() == 0);
			send_idle_pct = (phase == 1) ? 63 : (phase == 3 ? 7 : 0);
			for (int i = 0; i < 285; i++)
				queue_op(func_t'($urandom_range(0, 15)), rand_operand(), rand_operand());
		end
		wait (pending_ops.size() == 0);
		@(negedge clk);
		wait (expected_res.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("fixed_point_alu_top_tb: clean");
		else
			$display("fixed_point_alu_top_tb: errors");
		$finish;
	end

endmodule

[sim.f]
sv/fpa_pkg.sv
sv/fpa_div_cell.sv
sv/fpa_mul.sv
sv/fixed_point_alu_top.sv
tb/fixed_point_alu_top_tb.sv
